// ===== rtl/dcsp_pkg.sv =====
// Package for the detection class stream parser.
// Holds widths, payload and control structs, register codes and marker strings.
// Used by every module of the block; depends on nothing.
package dcsp_pkg;

  localparam int NUMBER_WIDTH = 16;
  localparam int TIMER_WIDTH  = 16;

  localparam int CFG_WIDTH       = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CLASS_POS_WIDTH = 4;

  localparam int TYPE_LEN   = 10;
  localparam int INVOKE_LEN = 16;
  localparam int BOXES_LEN  = 8;

  localparam int TYPE_POS_W   = $clog2(TYPE_LEN);
  localparam int INVOKE_POS_W = $clog2(INVOKE_LEN);
  localparam int BOXES_POS_W  = $clog2(BOXES_LEN);

  localparam logic [7:0] TYPE_MARKER [TYPE_LEN] = '{
    8'h7B, 8'h22, 8'h74, 8'h79, 8'h70, 8'h65, 8'h22, 8'h3A, 8'h20, 8'h31
  };
  localparam logic [7:0] INVOKE_MARKER [INVOKE_LEN] = '{
    8'h22, 8'h6E, 8'h61, 8'h6D, 8'h65, 8'h22, 8'h3A, 8'h20,
    8'h22, 8'h49, 8'h4E, 8'h56, 8'h4F, 8'h4B, 8'h45, 8'h22
  };
  localparam logic [7:0] BOXES_MARKER [BOXES_LEN] = '{
    8'h22, 8'h62, 8'h6F, 8'h78, 8'h65, 8'h73, 8'h22, 8'h3A
  };

  localparam logic [7:0] CHAR_OPEN  = 8'h5B;
  localparam logic [7:0] CHAR_CLOSE = 8'h5D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [7:0] DEPTH_MAX = 8'd255;
  localparam logic [7:0] BOX_DEPTH = 8'd2;
  localparam logic [CLASS_POS_WIDTH-1:0] INDEX_MAX = '1;

  localparam logic [CFG_WIDTH-1:0]       TIMEOUT_RESET   = 16'd1500;
  localparam logic [CFG_WIDTH-1:0]       ALARM_RESET     = 16'd3;
  localparam logic [CLASS_POS_WIDTH-1:0] CLASS_POS_RESET = 4'd5;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_TIMEOUT_MS     = 2'd0,
    CFG_ALARM_CLASS    = 2'd1,
    CFG_CLASS_POSITION = 2'd2
  } dcsp_cfg_index_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } dcsp_op_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } dcsp_in_t;

  typedef struct packed {
    logic green_led;
    logic red_led;
    logic timed_out;
  } dcsp_out_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0]       timeout_ms;
    logic [CFG_WIDTH-1:0]       alarm_class;
    logic [CLASS_POS_WIDTH-1:0] class_position;
  } dcsp_cfg_t;

  typedef struct packed {
    logic byte_step;
    logic tick_step;
  } dcsp_step_t;

endpackage

// ===== rtl/dcsp_idle_timer.sv =====
// Idle timer of the detection class stream parser.
// Counts millisecond ticks after the last received byte and flags the timeout clear.
// Depends on dcsp_pkg.
module dcsp_idle_timer
  import dcsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dcsp_step_t step,
  input  dcsp_cfg_t  cfg,
  output logic       fire
);

  localparam int CMP_W = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;

  logic                   timer_armed;
  logic [TIMER_WIDTH-1:0] idle_count;
  logic                   expired;

  assign expired = CMP_W'(idle_count) >= CMP_W'(cfg.timeout_ms);
  assign fire    = step.tick_step && timer_armed && expired;

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_armed <= 1'b0;
      idle_count  <= '0;
    end else if (step.byte_step) begin
      timer_armed <= 1'b1;
      idle_count  <= '0;
    end else if (step.tick_step && timer_armed) begin
      if (expired) begin
        timer_armed <= 1'b0;
        idle_count  <= '0;
      end else if (idle_count != '1) begin
        idle_count <= idle_count + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/dcsp_parser.sv =====
// Byte parser of the detection class stream parser.
// Holds the marker matchers, bracket and number tracking and the detection flags.
// Depends on dcsp_pkg.
module dcsp_parser
  import dcsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dcsp_step_t step,
  input  logic [7:0] data_byte,
  input  logic       clear,
  input  dcsp_cfg_t  cfg,
  output logic       has_other_next,
  output logic       has_alarm_next
);

  localparam int CMP_W = (NUMBER_WIDTH > CFG_WIDTH) ? NUMBER_WIDTH : CFG_WIDTH;
  localparam int EXT_W = NUMBER_WIDTH + 4;

  logic [TYPE_POS_W-1:0]      type_match_pos, type_match_pos_next;
  logic [INVOKE_POS_W-1:0]    invoke_match_pos, invoke_match_pos_next;
  logic [BOXES_POS_W-1:0]     boxes_match_pos, boxes_match_pos_next;
  logic                       invoke_seen, invoke_seen_next;
  logic                       in_boxes, in_boxes_next;
  logic [7:0]                 bracket_depth, bracket_depth_next;
  logic                       in_box, in_box_next;
  logic                       index_valid, index_valid_next;
  logic [CLASS_POS_WIDTH-1:0] value_index, value_index_next;
  logic [NUMBER_WIDTH-1:0]    number_value, number_value_next;
  logic                       in_number, in_number_next;
  logic                       has_other, has_alarm;

  logic                       type_hit, invoke_hit, boxes_hit;
  logic                       can_move, class_hit, is_alarm;
  logic [CLASS_POS_WIDTH-1:0] index_moved;
  logic                       is_digit;
  logic [EXT_W-1:0]           num_ext, num_sum;

  always_comb begin
    type_hit = 1'b0;
    if (data_byte == TYPE_MARKER[type_match_pos]) begin
      type_hit            = type_match_pos == TYPE_POS_W'(TYPE_LEN - 1);
      type_match_pos_next = type_hit ? '0 : type_match_pos + 1'b1;
    end else begin
      type_match_pos_next = (data_byte == TYPE_MARKER[0]) ? TYPE_POS_W'(1) : '0;
    end

    invoke_hit = 1'b0;
    if (data_byte == INVOKE_MARKER[invoke_match_pos]) begin
      invoke_hit            = invoke_match_pos == INVOKE_POS_W'(INVOKE_LEN - 1);
      invoke_match_pos_next = invoke_hit ? '0 : invoke_match_pos + 1'b1;
    end else begin
      invoke_match_pos_next = (data_byte == INVOKE_MARKER[0]) ? INVOKE_POS_W'(1) : '0;
    end

    boxes_hit = 1'b0;
    if (data_byte == BOXES_MARKER[boxes_match_pos]) begin
      boxes_hit            = boxes_match_pos == BOXES_POS_W'(BOXES_LEN - 1);
      boxes_match_pos_next = boxes_hit ? '0 : boxes_match_pos + 1'b1;
    end else begin
      boxes_match_pos_next = (data_byte == BOXES_MARKER[0]) ? BOXES_POS_W'(1) : '0;
    end
  end

  assign can_move    = !index_valid || (value_index != INDEX_MAX);
  assign index_moved = index_valid ? value_index + 1'b1 : '0;
  assign is_alarm    = CMP_W'(number_value) == CMP_W'(cfg.alarm_class);
  assign class_hit   = in_box && can_move && (index_moved == cfg.class_position);
  assign is_digit    = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
  assign num_ext     = EXT_W'(number_value);
  assign num_sum     = (num_ext << 3) + (num_ext << 1) + EXT_W'(data_byte[3:0]);

  logic [TYPE_POS_W-1:0]   type_pos_step;
  logic [INVOKE_POS_W-1:0] invoke_pos_step;
  logic [BOXES_POS_W-1:0]  boxes_pos_step;

  always_comb begin
    type_pos_step    = type_match_pos;
    invoke_pos_step  = invoke_match_pos;
    boxes_pos_step   = boxes_match_pos;
    invoke_seen_next = invoke_seen;
    in_boxes_next    = in_boxes;
    bracket_depth_next = bracket_depth;
    in_box_next      = in_box;
    index_valid_next = index_valid;
    value_index_next = value_index;
    number_value_next = number_value;
    in_number_next   = in_number;
    has_other_next   = has_other;
    has_alarm_next   = has_alarm;

    if (clear) begin
      has_other_next     = 1'b0;
      has_alarm_next     = 1'b0;
      invoke_seen_next   = 1'b0;
      in_boxes_next      = 1'b0;
      bracket_depth_next = '0;
      in_box_next        = 1'b0;
      index_valid_next   = 1'b0;
      number_value_next  = '0;
      in_number_next     = 1'b0;
    end else if (step.byte_step) begin
      type_pos_step = type_match_pos_next;
      if (type_hit) begin
        has_other_next     = 1'b0;
        has_alarm_next     = 1'b0;
        invoke_seen_next   = 1'b1;
        in_boxes_next      = 1'b0;
        bracket_depth_next = '0;
        in_box_next        = 1'b0;
        index_valid_next   = 1'b0;
        number_value_next  = '0;
        in_number_next     = 1'b0;
      end
      if (!invoke_seen_next) begin
        invoke_pos_step = invoke_match_pos_next;
        if (invoke_hit) begin
          invoke_seen_next = 1'b1;
        end
      end else if (!in_boxes_next) begin
        boxes_pos_step = boxes_match_pos_next;
        if (boxes_hit) begin
          in_boxes_next      = 1'b1;
          bracket_depth_next = '0;
          in_box_next        = 1'b0;
          index_valid_next   = 1'b0;
          in_number_next     = 1'b0;
          number_value_next  = '0;
        end
      end else if (data_byte == CHAR_OPEN) begin
        if (bracket_depth != DEPTH_MAX) begin
          bracket_depth_next = bracket_depth + 1'b1;
        end
        if (bracket_depth_next == BOX_DEPTH) begin
          in_box_next       = 1'b1;
          index_valid_next  = 1'b0;
          in_number_next    = 1'b0;
          number_value_next = '0;
        end
      end else if (data_byte == CHAR_CLOSE) begin
        if (in_number) begin
          if (can_move) begin
            index_valid_next = 1'b1;
            value_index_next = index_moved;
          end
          if (class_hit) begin
            has_alarm_next = has_alarm || is_alarm;
            has_other_next = has_other || !is_alarm;
          end
          in_number_next    = 1'b0;
          number_value_next = '0;
        end
        if (bracket_depth != '0) begin
          bracket_depth_next = bracket_depth - 1'b1;
        end
        if (bracket_depth_next < BOX_DEPTH) begin
          in_box_next      = 1'b0;
          index_valid_next = 1'b0;
        end
      end else if (in_box) begin
        if (is_digit) begin
          if (!in_number) begin
            number_value_next = NUMBER_WIDTH'(data_byte[3:0]);
          end else if (num_sum > EXT_W'({NUMBER_WIDTH{1'b1}})) begin
            number_value_next = '1;
          end else begin
            number_value_next = num_sum[NUMBER_WIDTH-1:0];
          end
          in_number_next = 1'b1;
        end else if (in_number) begin
          if (can_move) begin
            index_valid_next = 1'b1;
            value_index_next = index_moved;
          end
          if (class_hit) begin
            has_alarm_next = has_alarm || is_alarm;
            has_other_next = has_other || !is_alarm;
          end
          in_number_next    = 1'b0;
          number_value_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      type_match_pos   <= '0;
      invoke_match_pos <= '0;
      boxes_match_pos  <= '0;
      invoke_seen      <= 1'b0;
      in_boxes         <= 1'b0;
      bracket_depth    <= '0;
      in_box           <= 1'b0;
      index_valid      <= 1'b0;
      value_index      <= '0;
      number_value     <= '0;
      in_number        <= 1'b0;
      has_other        <= 1'b0;
      has_alarm        <= 1'b0;
    end else if (step.byte_step || clear) begin
      type_match_pos   <= type_pos_step;
      invoke_match_pos <= invoke_pos_step;
      boxes_match_pos  <= boxes_pos_step;
      invoke_seen      <= invoke_seen_next;
      in_boxes         <= in_boxes_next;
      bracket_depth    <= bracket_depth_next;
      in_box           <= in_box_next;
      index_valid      <= index_valid_next;
      value_index      <= value_index_next;
      number_value     <= number_value_next;
      in_number        <= in_number_next;
      has_other        <= has_other_next;
      has_alarm        <= has_alarm_next;
    end
  end

endmodule

// ===== rtl/detection_class_stream_parser.sv =====
// Top level of the detection class stream parser.
// Holds the configuration registers, the input register and the result register.
// Depends on dcsp_pkg, dcsp_parser and dcsp_idle_timer.
//
// Each input transaction carries either a received byte (op 0) or a one millisecond
// tick (op 1). Every input transaction yields exactly one output transaction that
// carries both LED states after the item and a flag telling whether a tick fired
// the idle timeout clear.
// An accepted item waits in the input register until it advances, which happens
// unless a valid result is stalled; its result is then captured in the result
// register. One item can be accepted per cycle while in_stall is low.
// The input register and the result register each hold one transaction, so a new
// item is still taken while a finished result waits. When the receiver stalls with
// both registers full, in_stall rises and the held result does not change.
// Reset clears all parse state, the LED flags and the idle timer, and loads the default
// configuration: a timeout of 1500 ticks, alarm class 3 and class position 5.
// Configuration writes through cfg_write, cfg_index and cfg_data take effect at the
// next edge; an index beyond the register list is ignored.
module detection_class_stream_parser
  import dcsp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  dcsp_in_t                   in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output dcsp_out_t                  out_data
);

  dcsp_cfg_t  cfg;
  logic       in_full;
  dcsp_in_t   in_reg;
  logic       advance;
  dcsp_step_t step;
  logic       fire;
  logic       has_other_next;
  logic       has_alarm_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ms     <= TIMEOUT_RESET;
      cfg.alarm_class    <= ALARM_RESET;
      cfg.class_position <= CLASS_POS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TIMEOUT_MS:     cfg.timeout_ms     <= cfg_data;
        CFG_ALARM_CLASS:    cfg.alarm_class    <= cfg_data;
        CFG_CLASS_POSITION: cfg.class_position <= cfg_data[CLASS_POS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = in_full && !(out_valid && out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= in_data;
    end
  end

  assign step.byte_step = advance && (in_reg.op == OP_BYTE);
  assign step.tick_step = advance && (in_reg.op == OP_TICK);

  dcsp_idle_timer u_timer (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cfg  (cfg),
    .fire (fire)
  );

  dcsp_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .data_byte      (in_reg.data_byte),
    .clear          (fire),
    .cfg            (cfg),
    .has_other_next (has_other_next),
    .has_alarm_next (has_alarm_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.green_led <= has_other_next;
      out_data.red_led   <= has_alarm_next;
      out_data.timed_out <= fire;
    end
  end

endmodule
